// ----- sv/cgs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared types and constants for the seven-tap curve smoother.
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int COORD_BITS = 24;
  localparam int TAPS       = 7;
  localparam int HALF_TAPS  = 3;

  localparam int WEIGHT_BITS    = 16;
  localparam int RECIP_BITS     = 18;
  localparam int CFG_DATA_BITS  = 18;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_CENTER = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_ONE    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_TWO    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WEIGHT_THREE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NORM_RECIP    = 3'd4;

  localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT_CENTER = 16'd26146;
  localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT_ONE    = 16'd15860;
  localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT_TWO    = 16'd3539;
  localparam logic [WEIGHT_BITS-1:0] RST_WEIGHT_THREE  = 16'd291;
  localparam logic [RECIP_BITS-1:0]  RST_NORM_RECIP    = 18'd65536;

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   point_last;
  } point_t;

  typedef struct packed {
    coord_t smooth_x;
    coord_t smooth_y;
    logic   smooth_last;
  } result_t;

  // one window snapshot to be smoothed
  typedef struct packed {
    coord_t [TAPS-1:0] win_x;
    coord_t [TAPS-1:0] win_y;
    logic              last;
  } job_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight_center;
    logic [WEIGHT_BITS-1:0] weight_one_away;
    logic [WEIGHT_BITS-1:0] weight_two_away;
    logic [WEIGHT_BITS-1:0] weight_three_away;
    logic [RECIP_BITS-1:0]  norm_reciprocal;
  } cfg_t;

endpackage

// ----- sv/curve_gaussian_smoother.sv -----
// ----------------------------------------------------------------------------
// curve_gaussian_smoother
// Seven-tap symmetric smoothing of a streamed curve, end points replicated.
// ----------------------------------------------------------------------------
// Flow: each pushed window waits in the queue until the back end pops it and
//   runs it through the shared datapath (4 kernel multiply-accumulate steps,
//   abs, 2-step reciprocal multiply, round/saturate), one window at a time,
//   held while output is busy. A curve's final point flushes up to 4 results.
// Reset: synchronous; clears window, point count, queue and output, and
//   loads the default weights. No clearing pass.
module curve_gaussian_smoother (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  cgs_pkg::point_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output cgs_pkg::result_t                     out_data,
  input  logic                                 cfg_write,
  input  logic [cgs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [cgs_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  cgs_pkg::cfg_t cfg;
  logic          q_ready;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  cgs_pkg::job_t q_in;
  cgs_pkg::job_t q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_center     <= cgs_pkg::RST_WEIGHT_CENTER;
      cfg.weight_one_away   <= cgs_pkg::RST_WEIGHT_ONE;
      cfg.weight_two_away   <= cgs_pkg::RST_WEIGHT_TWO;
      cfg.weight_three_away <= cgs_pkg::RST_WEIGHT_THREE;
      cfg.norm_reciprocal   <= cgs_pkg::RST_NORM_RECIP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cgs_pkg::CFG_WEIGHT_CENTER:
          cfg.weight_center <= cfg_data[cgs_pkg::WEIGHT_BITS-1:0];
        cgs_pkg::CFG_WEIGHT_ONE:
          cfg.weight_one_away <= cfg_data[cgs_pkg::WEIGHT_BITS-1:0];
        cgs_pkg::CFG_WEIGHT_TWO:
          cfg.weight_two_away <= cfg_data[cgs_pkg::WEIGHT_BITS-1:0];
        cgs_pkg::CFG_WEIGHT_THREE:
          cfg.weight_three_away <= cfg_data[cgs_pkg::WEIGHT_BITS-1:0];
        cgs_pkg::CFG_NORM_RECIP:
          cfg.norm_reciprocal <= cfg_data[cgs_pkg::RECIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  cgs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  cgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  cgs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- sv/cgs_front.sv -----
// ----------------------------------------------------------------------------
// cgs_front
// Keeps the seven-point window, handles curve start and end replication and
// hands window snapshots to the job queue.
// ----------------------------------------------------------------------------
module cgs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cgs_pkg::point_t in_data,
  input  logic            q_ready,
  output logic            q_push,
  output cgs_pkg::job_t   q_data
);

  typedef enum logic {F_IDLE, F_FLUSH} fstate_t;

  fstate_t         state;
  logic [1:0]      seen;
  logic [1:0]      seen_keep;
  logic [1:0]      flush_step;
  cgs_pkg::coord_t wx [cgs_pkg::TAPS];
  cgs_pkg::coord_t wy [cgs_pkg::TAPS];
  cgs_pkg::coord_t wx_next [cgs_pkg::TAPS];
  cgs_pkg::coord_t wy_next [cgs_pkg::TAPS];
  logic            in_fire;
  logic            flush_go;
  logic [2:0]      flush_pos;

  assign in_ready  = (state == F_IDLE) && q_ready;
  assign in_fire   = in_valid && in_ready;
  assign flush_go  = (state == F_FLUSH) && q_ready;
  assign flush_pos = {1'b0, flush_step} + {1'b0, seen_keep};

  always_comb begin
    for (int k = 0; k < cgs_pkg::TAPS; k++) begin
      wx_next[k] = wx[k];
      wy_next[k] = wy[k];
    end
    if (in_fire && seen == 2'd0) begin
      for (int k = 0; k < cgs_pkg::TAPS; k++) begin
        wx_next[k] = in_data.point_x;
        wy_next[k] = in_data.point_y;
      end
    end else if (in_fire || flush_go) begin
      for (int k = 0; k < cgs_pkg::TAPS - 1; k++) begin
        wx_next[k] = wx[k+1];
        wy_next[k] = wy[k+1];
      end
      wx_next[cgs_pkg::TAPS-1] = in_fire ? in_data.point_x : wx[cgs_pkg::TAPS-1];
      wy_next[cgs_pkg::TAPS-1] = in_fire ? in_data.point_y : wy[cgs_pkg::TAPS-1];
    end
  end

  always_comb begin
    for (int k = 0; k < cgs_pkg::TAPS; k++) begin
      q_data.win_x[k] = wx_next[k];
      q_data.win_y[k] = wy_next[k];
    end
    q_data.last = flush_go && (flush_step == 2'd3);
    q_push = (in_fire && seen == 2'd3) || (flush_go && flush_pos >= 3'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      seen       <= 2'd0;
      seen_keep  <= 2'd0;
      flush_step <= 2'd0;
      for (int k = 0; k < cgs_pkg::TAPS; k++) begin
        wx[k] <= '0;
        wy[k] <= '0;
      end
    end else begin
      for (int k = 0; k < cgs_pkg::TAPS; k++) begin
        wx[k] <= wx_next[k];
        wy[k] <= wy_next[k];
      end
      unique case (state)
        F_IDLE: begin
          if (in_fire) begin
            if (in_data.point_last) begin
              state      <= F_FLUSH;
              seen_keep  <= seen;
              seen       <= 2'd0;
              flush_step <= 2'd1;
            end else if (seen != 2'd3) begin
              seen <= seen + 2'd1;
            end
          end
        end
        F_FLUSH: begin
          if (flush_go) begin
            flush_step <= flush_step + 2'd1;
            if (flush_step == 2'd3) begin
              state <= F_IDLE;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  a_last_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_data.point_last) |=> (state == F_FLUSH && seen == 2'd0))
    else $error("last point did not start flush");

  a_flush_ends: assert property (@(posedge clk) disable iff (rst)
    (flush_go && flush_step == 2'd3) |=> (state == F_IDLE && !q_push))
    else $error("flush did not end after three steps");

endmodule

// ----- sv/cgs_queue.sv -----
// ----------------------------------------------------------------------------
// cgs_queue
// Two-entry job queue between window front and arithmetic back.
// ----------------------------------------------------------------------------
module cgs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cgs_pkg::job_t push_data,
  output logic          ready,
  output logic          valid,
  input  logic          pop,
  output cgs_pkg::job_t pop_data
);

  localparam int PTR_BITS = $clog2(cgs_pkg::QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(cgs_pkg::QUEUE_DEPTH + 1);

  cgs_pkg::job_t        mem [cgs_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [CNT_BITS-1:0]  count;

  assign ready    = count != CNT_BITS'(cgs_pkg::QUEUE_DEPTH);
  assign valid    = count != '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(cgs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(cgs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ready)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("pop from empty queue");

endmodule

// ----- sv/cgs_back.sv -----
// ----------------------------------------------------------------------------
// cgs_back
// Weighted kernel sum, reciprocal scaling, rounding and saturation for one
// window at a time, x and y side by side.
// ----------------------------------------------------------------------------
module cgs_back (
  input  logic             clk,
  input  logic             rst,
  input  cgs_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  cgs_pkg::job_t    q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output cgs_pkg::result_t out_data
);

  localparam int CB    = cgs_pkg::COORD_BITS;
  localparam int RB    = cgs_pkg::RECIP_BITS;
  localparam int WB    = cgs_pkg::WEIGHT_BITS;
  localparam int HT    = cgs_pkg::HALF_TAPS;
  localparam int PAIRS = HT + 1;
  localparam int MACW  = CB + 1 + WB + 1;
  localparam int AW    = CB + 19;
  localparam int MW    = AW - 1;
  localparam int LO_W  = MW / 2;
  localparam int HI_W  = MW - LO_W;
  localparam int PW    = MW + RB;
  localparam int RNDW  = PW - 31;

  typedef logic signed [CB:0] pair_t;
  typedef enum logic [2:0] {B_IDLE, B_MAC, B_ABS, B_MUL_LO, B_MUL_HI, B_ROUND} bstate_t;

  bstate_t                state;
  logic [1:0]             step;
  logic                   last;
  pair_t                  ps_x [PAIRS];
  pair_t                  ps_y [PAIRS];
  logic signed [AW-1:0]   acc_x, acc_y;
  logic                   neg_x, neg_y;
  logic [MW-1:0]          mag_x, mag_y;
  logic [PW-1:0]          pr_x, pr_y;

  logic [WB-1:0]          w_sel;
  logic signed [MACW-1:0] mac_x, mac_y;
  logic signed [AW-1:0]   abs_x, abs_y;
  logic [LO_W+RB-1:0]     plo_x, plo_y;
  logic [HI_W+RB-1:0]     phi_x, phi_y;
  logic                   out_free;

  function automatic cgs_pkg::coord_t round_sat(input logic [PW-1:0] p, input logic neg);
    logic [PW:0]      s;
    logic [RNDW-1:0]  r;
    logic [RNDW-1:0]  lim;
    s   = {1'b0, p} + ((PW+1)'(1) << 31);
    r   = s[PW:32];
    lim = RNDW'(1) << (CB - 1);
    if (neg) begin
      round_sat = (r > lim) ? cgs_pkg::coord_t'(lim[CB-1:0]) : -r[CB-1:0];
    end else begin
      round_sat = (r > lim - 1'b1) ? cgs_pkg::coord_t'(lim[CB-1:0] - 1'b1) : r[CB-1:0];
    end
  endfunction

  always_comb begin
    unique case (step)
      2'd0: w_sel = cfg.weight_center;
      2'd1: w_sel = cfg.weight_one_away;
      2'd2: w_sel = cfg.weight_two_away;
      2'd3: w_sel = cfg.weight_three_away;
      default: w_sel = cfg.weight_center;
    endcase
  end

  assign mac_x    = ps_x[0] * $signed({1'b0, w_sel});
  assign mac_y    = ps_y[0] * $signed({1'b0, w_sel});
  assign abs_x    = acc_x[AW-1] ? -acc_x : acc_x;
  assign abs_y    = acc_y[AW-1] ? -acc_y : acc_y;
  assign plo_x    = mag_x[LO_W-1:0] * cfg.norm_reciprocal;
  assign plo_y    = mag_y[LO_W-1:0] * cfg.norm_reciprocal;
  assign phi_x    = mag_x[MW-1:LO_W] * cfg.norm_reciprocal;
  assign phi_y    = mag_y[MW-1:LO_W] * cfg.norm_reciprocal;
  assign q_pop    = (state == B_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_ROUND && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            state    <= B_MAC;
            step     <= 2'd0;
            last     <= q_data.last;
            acc_x    <= '0;
            acc_y    <= '0;
            ps_x[0]  <= {q_data.win_x[HT][CB-1], q_data.win_x[HT]};
            ps_y[0]  <= {q_data.win_y[HT][CB-1], q_data.win_y[HT]};
            for (int d = 1; d < PAIRS; d++) begin
              ps_x[d] <= {q_data.win_x[HT-d][CB-1], q_data.win_x[HT-d]}
                       + {q_data.win_x[HT+d][CB-1], q_data.win_x[HT+d]};
              ps_y[d] <= {q_data.win_y[HT-d][CB-1], q_data.win_y[HT-d]}
                       + {q_data.win_y[HT+d][CB-1], q_data.win_y[HT+d]};
            end
          end
        end
        B_MAC: begin
          acc_x <= acc_x + AW'(mac_x);
          acc_y <= acc_y + AW'(mac_y);
          for (int d = 0; d < PAIRS - 1; d++) begin
            ps_x[d] <= ps_x[d+1];
            ps_y[d] <= ps_y[d+1];
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= B_ABS;
          end
        end
        B_ABS: begin
          neg_x <= acc_x[AW-1];
          neg_y <= acc_y[AW-1];
          mag_x <= abs_x[MW-1:0];
          mag_y <= abs_y[MW-1:0];
          state <= B_MUL_LO;
        end
        B_MUL_LO: begin
          pr_x  <= PW'(plo_x);
          pr_y  <= PW'(plo_y);
          state <= B_MUL_HI;
        end
        B_MUL_HI: begin
          pr_x  <= pr_x + (PW'(phi_x) << LO_W);
          pr_y  <= pr_y + (PW'(phi_y) << LO_W);
          state <= B_ROUND;
        end
        B_ROUND: begin
          if (out_free) begin
            out_data.smooth_x    <= round_sat(pr_x, neg_x);
            out_data.smooth_y    <= round_sat(pr_y, neg_y);
            out_data.smooth_last <= last;
            state                <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_pop_starts_mac: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == B_MAC && step == 2'd0))
    else $error("job pop did not start kernel sum");

  a_round_held: assert property (@(posedge clk) disable iff (rst)
    (state == B_ROUND && !out_free) |=> (state == B_ROUND && out_valid))
    else $error("result lost while output slot busy");

endmodule
